FILE: design/tlpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_pkg
// Shared types and constants of the two-layer pixel mixer with sparkle.
// ----------------------------------------------------------------------------
package tlpm_pkg;

   localparam int unsigned NODES_DEF = 1024;

   localparam int NODE_W  = 10;
   localparam int COLOR_W = 24;
   localparam int CNT_W   = 32;
   localparam int FREQ_W  = 8;
   localparam int MODE_W  = 3;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [COLOR_W-1:0] GREY_MID  = 24'h888888;
   localparam logic [COLOR_W-1:0] GREY_HIGH = 24'hBBBBBB;
   localparam logic [COLOR_W-1:0] WHITE     = 24'hFFFFFF;

   // register select, taken from the word address bit of the csr port
   localparam logic REG_MIX_MODE     = 1'b0;
   localparam logic REG_SPARKLE_FREQ = 1'b1;

   localparam logic KIND_RENDER = 1'b0;
   localparam logic KIND_LOAD   = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MIX_LAYER1 = 3'd0,
      MIX_LAYER2 = 3'd1,
      MIX_HOLE_A = 3'd2,
      MIX_HOLE_B = 3'd3,
      MIX_GATE_A = 3'd4,
      MIX_GATE_B = 3'd5,
      MIX_STACK  = 3'd6,
      MIX_BLEND  = 3'd7
   } mix_mode_type;

   typedef struct packed {
      logic              done;
      logic [FREQ_W-1:0] remainder;
   } rem_status_type;

endpackage

FILE: design/two_layer_pixel_mixer_sparkle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_layer_pixel_mixer_sparkle_core
// Mixes two layer colors per light node and overlays a per-node sparkle.
//
// A request transfer on req_* carries either a render item (kind 0) or a
// counter load (kind 1). A load writes the node's sparkle counter in the
// cycle it is taken and gives no response. A render item gives one response
// transfer on rsp_* with the node index and the final color.
// A render item passes the mix step and, when sparkle applies, has its
// counter reduced modulo sparkle_freq; the remainder comes from a shared
// restoring divider that retires one dividend bit per cycle over 32 bits.
// One item is worked on at a time; req_ready is low while it is in flight.
// A finished response sits in an output register, so the next request is
// taken while it waits; a stalled receiver holds the response and keeps
// the next render item from finishing.
// After reset the counter store is swept to zero, one node per cycle, over
// all NODES nodes; requests are refused meanwhile, csr writes are taken.
// mix_mode and sparkle_freq sit on the csr port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module two_layer_pixel_mixer_sparkle_core
   import tlpm_pkg::*;
#(
   parameter int unsigned NODES = NODES_DEF
)
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [NODE_W-1:0]  req_node_index,
   input  logic               req_mapped,
   input  logic [COLOR_W-1:0] req_color_a,
   input  logic [COLOR_W-1:0] req_color_b,
   input  logic [CNT_W-1:0]   req_seed_value,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [NODE_W-1:0]  rsp_out_node,
   output logic [COLOR_W-1:0] rsp_out_color,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_DIV,
      ST_OUT
   } state_type;

   // configuration
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mode_in = mode_ff;
      freq_in = freq_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_MIX_MODE:     mode_in = csr_pwdata[MODE_W-1:0];
            REG_SPARKLE_FREQ: freq_in = csr_pwdata[FREQ_W-1:0];
            default:          mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         freq_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         freq_ff <= freq_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MIX_MODE:     csr_prdata = CSR_DW'(mode_ff);
         REG_SPARKLE_FREQ: csr_prdata = CSR_DW'(freq_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // item datapath and sequencer
   state_type          state_ff, state_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic               mapped_ff, mapped_in;
   logic               in_range_ff, in_range_in;
   logic [COLOR_W-1:0] ca_ff, ca_in;
   logic [COLOR_W-1:0] cb_ff, cb_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]  rsp_node_ff, rsp_node_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   logic               req_xfer;
   logic               req_in_range;
   logic [COLOR_W-1:0] mix_color;
   logic [COLOR_W-1:0] sparkle_color;
   logic               sparkle_go;

   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [CNT_W-1:0]   mem_wr_data;
   logic               mem_rd_en;
   logic [CNT_W-1:0]   mem_rd_data;
   logic               clearing;

   logic               rem_start;
   rem_status_type     rem_st;

   tlpm_mixer u_mixer (
      .mode      (mix_mode_type'(mode_ff)),
      .color_a   (ca_ff),
      .color_b   (cb_ff),
      .color_mix (mix_color)
   );

   tlpm_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (mem_rd_data),
      .divisor  (freq_ff),
      .status   (rem_st)
   );

   tlpm_counter_mem #(
      .NODES (NODES),
      .AW    (AW)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data),
      .rd_en    (mem_rd_en),
      .rd_addr  (AW'(req_node_index)),
      .rd_data  (mem_rd_data),
      .clearing (clearing)
   );

   assign req_ready    = (state_ff == ST_IDLE) && !clearing;
   assign req_xfer     = req_valid && req_ready;
   assign req_in_range = (32'(req_node_index) < 32'(NODES));
   assign sparkle_go   = mapped_ff && in_range_ff && (freq_ff != '0) && (mix_color != '0);

   always_comb begin
      unique case (rem_st.remainder)
         8'd2, 8'd6: sparkle_color = GREY_MID;
         8'd3, 8'd5: sparkle_color = GREY_HIGH;
         8'd4:       sparkle_color = WHITE;
         default:    sparkle_color = color_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      mapped_in    = mapped_ff;
      in_range_in  = in_range_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      color_in     = color_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_node_in  = rsp_node_ff;
      rsp_color_in = rsp_color_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = AW'(req_node_index);
      mem_wr_data  = req_seed_value;
      mem_rd_en    = 1'b0;
      rem_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_kind == KIND_LOAD) begin
                  mem_wr_en = req_in_range;
               end else begin
                  node_in     = req_node_index;
                  mapped_in   = req_mapped;
                  in_range_in = req_in_range;
                  ca_in       = req_color_a;
                  cb_in       = req_color_b;
                  mem_rd_en   = 1'b1;
                  state_in    = ST_MIX;
               end
            end
         end
         ST_MIX: begin
            color_in = mapped_ff ? mix_color : '0;
            if (sparkle_go) begin
               rem_start = 1'b1;
               cnt_in    = mem_rd_data;
               state_in  = ST_DIV;
            end else begin
               state_in  = ST_OUT;
            end
         end
         ST_DIV: begin
            if (rem_st.done) begin
               color_in    = sparkle_color;
               mem_wr_en   = 1'b1;
               mem_wr_addr = AW'(node_ff);
               mem_wr_data = cnt_ff + 1'b1;
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            // output register frees up when empty or taken this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = node_ff;
               rsp_color_in = color_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff      <= node_in;
      mapped_ff    <= mapped_in;
      in_range_ff  <= in_range_in;
      ca_ff        <= ca_in;
      cb_ff        <= cb_in;
      color_ff     <= color_in;
      cnt_ff       <= cnt_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_node  = rsp_node_ff;
   assign rsp_out_color = rsp_color_ff;

   // checks
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      rem_st.done |-> (state_ff == ST_DIV))
      else $error("remainder finished outside of the divide state");

   a_render_to_mix: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_kind == KIND_RENDER)) |=> (state_ff == ST_MIX))
      else $error("render transfer did not start the mix step");

   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !clearing)
      else $error("counter write during the clearing sweep");

   a_start_only_in_mix: assert property (@(posedge clock) disable iff (reset)
      rem_start |-> ((state_ff == ST_MIX) && (freq_ff != '0)))
      else $error("divider started without a nonzero modulus");

endmodule

FILE: design/tlpm_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_mixer
// Blends two layer colors according to the mix mode.
// ----------------------------------------------------------------------------
module tlpm_mixer
   import tlpm_pkg::*;
(
   input  mix_mode_type       mode,
   input  logic [COLOR_W-1:0] color_a,
   input  logic [COLOR_W-1:0] color_b,
   output logic [COLOR_W-1:0] color_mix
);

   logic               a_black;
   logic               b_black;
   logic [COLOR_W-1:0] avg;

   assign a_black = (color_a == '0);
   assign b_black = (color_b == '0);

   // per-channel halved sum, truncated
   always_comb begin
      for (int ch = 0; ch < COLOR_W / 8; ch++) begin
         avg[ch*8 +: 8] = 8'(({1'b0, color_a[ch*8 +: 8]} + {1'b0, color_b[ch*8 +: 8]}) >> 1);
      end
   end

   always_comb begin
      unique case (mode)
         MIX_LAYER1: color_mix = color_a;
         MIX_LAYER2: color_mix = color_b;
         MIX_HOLE_A: color_mix = a_black ? color_b : '0;
         MIX_HOLE_B: color_mix = b_black ? color_a : '0;
         MIX_GATE_A: color_mix = a_black ? '0 : color_b;
         MIX_GATE_B: color_mix = b_black ? '0 : color_a;
         MIX_STACK:  color_mix = b_black ? color_a : color_b;
         MIX_BLEND:  color_mix = a_black ? color_b : (b_black ? color_a : avg);
         default:    color_mix = color_a;
      endcase
   end

endmodule

FILE: design/tlpm_rem_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_rem_unit
// Restoring remainder of a 32-bit counter by an 8-bit modulus, one bit a cycle.
// ----------------------------------------------------------------------------
module tlpm_rem_unit
   import tlpm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CNT_W-1:0]  dividend,
   input  logic [FREQ_W-1:0] divisor,
   output rem_status_type    status
);

   localparam int STEP_W = $clog2(CNT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  dvd_ff, dvd_in;
   logic [FREQ_W-1:0] rem_ff, rem_in;
   logic [FREQ_W-1:0] dsr_ff, dsr_in;

   logic [FREQ_W:0]   shifted;
   logic [FREQ_W:0]   diff;
   logic              fits;

   assign shifted = {rem_ff, dvd_ff[CNT_W-1]};
   assign fits    = (shifted >= {1'b0, dsr_ff});
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
         dvd_in  = {dvd_ff[CNT_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CNT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

FILE: design/tlpm_counter_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_counter_mem
// Per-node sparkle counter store, one write and one registered read port,
// zeroed by a sweep after reset.
// ----------------------------------------------------------------------------
module tlpm_counter_mem
   import tlpm_pkg::*;
#(
   parameter int unsigned NODES = NODES_DEF,
   parameter int          AW    = (NODES > 1) ? $clog2(NODES) : 1
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [CNT_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [CNT_W-1:0] rd_data,
   output logic             clearing
);

   logic [CNT_W-1:0] mem [NODES];

   logic             clr_busy_ff, clr_busy_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0] rd_data_ff;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(NODES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;

endmodule
